// ----- rtl/core/bq_iir_pkg.sv -----
package bq_iir_pkg;

    localparam int NUM_COEF  = 5;
    localparam int CFG_IDX_W = 3;
    // state operands are split into digits of this width for the multiplier
    localparam int DIG_W     = 24;
    localparam int PC_W      = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        COEF_A1 = 3'd0,
        COEF_A2 = 3'd1,
        COEF_B0 = 3'd2,
        COEF_B1 = 3'd3,
        COEF_B2 = 3'd4
    } t_coef_idx;

    typedef enum logic [1:0] {
        OPND_D1,
        OPND_D2,
        OPND_W
    } t_opnd;

    typedef enum logic [1:0] {
        SUM_NONE,
        SUM_ADD,
        SUM_SUB,
        SUM_CLR
    } t_sum_op;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_LOOP,
        JMP_WAIT_IN,
        JMP_WAIT_OUT
    } t_jump;

    typedef enum logic [PC_W-1:0] {
        PC_IDLE   = 4'd0,
        PC_MUL_A1 = 4'd1,
        PC_DRN_A1 = 4'd2,
        PC_MUL_A2 = 4'd3,
        PC_DRN_A2 = 4'd4,
        PC_SUB_A2 = 4'd5,
        PC_WSAT   = 4'd6,
        PC_MUL_B0 = 4'd7,
        PC_DRN_B0 = 4'd8,
        PC_MUL_B1 = 4'd9,
        PC_DRN_B1 = 4'd10,
        PC_MUL_B2 = 4'd11,
        PC_DRN_B2 = 4'd12,
        PC_ADD_B2 = 4'd13,
        PC_OUT    = 4'd14
    } t_pc;

    typedef struct packed {
        logic      mul_en;
        t_coef_idx csel;
        t_opnd     osel;
        t_sum_op   sum_op;
        logic      wsat;
        t_jump     jump;
    } t_uword;

    typedef struct packed {
        logic      mul_en;
        t_coef_idx csel;
        t_opnd     osel;
        t_sum_op   sum_op;
        logic      wsat;
        logic      take_in;
        logic      emit;
    } t_ctrl;

    // control store: sum ops on a loop step act on its first digit only,
    // where the previous product has just drained
    function automatic t_uword ucode(t_pc pc);
        t_uword u;
        u = '{mul_en: 1'b0, csel: COEF_A1, osel: OPND_D1, sum_op: SUM_NONE,
              wsat: 1'b0, jump: JMP_NEXT};
        case (pc)
            PC_IDLE: begin
                u.jump = JMP_WAIT_IN;
            end
            PC_MUL_A1: begin
                u.mul_en = 1'b1; u.csel = COEF_A1; u.osel = OPND_D1;
                u.jump = JMP_LOOP;
            end
            PC_MUL_A2: begin
                u.mul_en = 1'b1; u.csel = COEF_A2; u.osel = OPND_D2;
                u.sum_op = SUM_SUB; u.jump = JMP_LOOP;
            end
            PC_SUB_A2: begin
                u.sum_op = SUM_SUB;
            end
            PC_WSAT: begin
                u.wsat = 1'b1; u.sum_op = SUM_CLR;
            end
            PC_MUL_B0: begin
                u.mul_en = 1'b1; u.csel = COEF_B0; u.osel = OPND_W;
                u.jump = JMP_LOOP;
            end
            PC_MUL_B1: begin
                u.mul_en = 1'b1; u.csel = COEF_B1; u.osel = OPND_D1;
                u.sum_op = SUM_ADD; u.jump = JMP_LOOP;
            end
            PC_MUL_B2: begin
                u.mul_en = 1'b1; u.csel = COEF_B2; u.osel = OPND_D2;
                u.sum_op = SUM_ADD; u.jump = JMP_LOOP;
            end
            PC_ADD_B2: begin
                u.sum_op = SUM_ADD;
            end
            PC_OUT: begin
                u.jump = JMP_WAIT_OUT;
            end
            default: begin
                u.jump = JMP_NEXT;
            end
        endcase
        return u;
    endfunction

    // Q2.30 reset set rescaled to cw bits, floor when narrowing
    function automatic logic signed [63:0] coef_reset(t_coef_idx idx, int cw);
        logic signed [63:0] v;
        case (idx)
            COEF_A1: v = -64'sd1988727151;
            COEF_A2: v = 64'sd925939788;
            COEF_B0: v = 64'sd997102192;
            COEF_B1: v = -64'sd1994204383;
            COEF_B2: v = 64'sd997102192;
            default: v = '0;
        endcase
        return (v <<< 16) >>> (48 - cw);
    endfunction

endpackage

// ----- rtl/core/bq_iir_seq.sv -----
module bq_iir_seq
    import bq_iir_pkg::*;
#(
    parameter int NDIG = 2
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_out_free,
    output t_ctrl                     o_ctrl,
    output logic [$clog2(NDIG)-1:0]   o_digit,
    output logic                      o_in_ready
);

    localparam int CNT_W = $clog2(NDIG);

    t_pc              r_pc, n_pc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_uword           uw;
    logic             last_dig;

    assign uw       = ucode(r_pc);
    assign last_dig = (r_cnt == CNT_W'(NDIG - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= PC_IDLE;
            r_cnt <= '0;
        end else begin
            r_pc  <= n_pc;
            r_cnt <= n_cnt;
        end
    end

    // next step
    always_comb begin
        n_pc  = r_pc;
        n_cnt = r_cnt;
        case (uw.jump)
            JMP_NEXT: begin
                n_pc = t_pc'(r_pc + 1'b1);
            end
            JMP_LOOP: begin
                if (last_dig) begin
                    n_pc  = t_pc'(r_pc + 1'b1);
                    n_cnt = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            JMP_WAIT_IN: begin
                if (i_in_valid) begin
                    n_pc = t_pc'(r_pc + 1'b1);
                end
            end
            JMP_WAIT_OUT: begin
                if (i_out_free) begin
                    n_pc = PC_IDLE;
                end
            end
            default: begin
                n_pc = PC_IDLE;
            end
        endcase
    end

    // datapath controls
    always_comb begin
        o_ctrl.mul_en  = uw.mul_en;
        o_ctrl.csel    = uw.csel;
        o_ctrl.osel    = uw.osel;
        o_ctrl.sum_op  = (r_cnt == '0) ? uw.sum_op : SUM_NONE;
        o_ctrl.wsat    = uw.wsat;
        o_ctrl.take_in = (uw.jump == JMP_WAIT_IN) && i_in_valid;
        o_ctrl.emit    = (uw.jump == JMP_WAIT_OUT) && i_out_free;
        o_in_ready     = (uw.jump == JMP_WAIT_IN);
        o_digit        = r_cnt;
    end

endmodule

// ----- rtl/core/biquad_iir_direct_form_ii.sv -----
// Biquad IIR filter, direct form II, one Q1.15 sample in and one out per beat.
// Coefficients are COEF_WIDTH-bit Q2.xx values written through the cfg port
// (index 0..4: a1, a2, b0, b1, b2); the user must write them only while the
// filter is idle, which the block itself does not enforce. Reset loads an
// 800 Hz high-pass set. A small microcoded sequencer drives one signed
// coefficient-by-24-bit-digit multiplier: each of the five products takes
// NDIG = ceil(STATE_WIDTH/24) multiply steps plus one drain step.
// The result goes to an output register; the sequencer holds at its last step
// until that register is free or being drained, then takes the next sample,
// even while that result still waits to be accepted.
module biquad_iir_direct_form_ii
    import bq_iir_pkg::*;
#(
    parameter int STATE_WIDTH = 40,
    parameter int COEF_WIDTH  = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [15:0]           i_sample_in,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [15:0]           o_sample_out,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [COEF_WIDTH-1:0]        i_cfg_data
);

    localparam int SW    = STATE_WIDTH;
    localparam int CW    = COEF_WIDTH;
    localparam int CF    = CW - 2;
    localparam int NDIG  = (SW + DIG_W - 1) / DIG_W;
    localparam int CNT_W = $clog2(NDIG);
    localparam int OPW   = NDIG * DIG_W;
    localparam int PPW   = CW + DIG_W + 1;
    localparam int PW    = CW + SW;
    localparam int SCW   = SW + 2;
    localparam int SUMW  = SW + 4;
    localparam int IN_SH = SW - 31;
    localparam int QW    = SUMW - IN_SH;
    localparam int EXTW  = (SW + 3 > 64) ? SW + 3 : 64;

    localparam logic signed [EXTW-1:0] PROD_LIM = EXTW'(64'sh2000_0000_0000_0000);
    localparam logic signed [EXTW-1:0] NEG_LIM  = -PROD_LIM;
    localparam logic signed [SUMW-1:0] RND_BIAS = {{QW{1'b0}}, {IN_SH{1'b1}}};

    t_ctrl              ctrl;
    logic [CNT_W-1:0]   digit;
    logic               out_free;

    logic signed [CW-1:0]   r_coef [NUM_COEF];
    logic signed [SW-1:0]   r_d1, r_d2, r_w;
    logic signed [SUMW-1:0] r_sum;
    logic signed [PW-1:0]   r_prod;
    logic signed [PPW-1:0]  r_pp;
    logic                   r_pp_vld;
    logic                   r_pp_first;
    logic [CNT_W-1:0]       r_pp_k;
    logic                   r_out_valid;
    logic signed [15:0]     r_sample_out;

    logic signed [SW-1:0]   opnd;
    logic signed [OPW-1:0]  opnd_ext;
    logic [DIG_W-1:0]       dig_raw;
    logic signed [DIG_W:0]  dig_s;
    logic signed [PW-1:0]   pp_ext;
    logic signed [PW-1:0]   pp_sh;
    logic signed [SCW-1:0]  sc;
    logic signed [EXTW-1:0] sc_ext;
    logic signed [EXTW-1:0] sc_clamp;
    logic signed [SUMW-1:0] prod_term;
    logic signed [SUMW-1:0] x_in;
    logic                   w_fits;
    logic signed [SW-1:0]   w_sat;
    logic signed [SUMW-1:0] y_biased;
    logic signed [QW-1:0]   q;
    logic                   q_fits;
    logic signed [15:0]     y_sat;

    assign out_free = !r_out_valid || i_out_ready;

    bq_iir_seq #(
        .NDIG (NDIG)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .o_ctrl     (ctrl),
        .o_digit    (digit),
        .o_in_ready (o_in_ready)
    );

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEF; i++) begin
                r_coef[i] <= CW'(coef_reset(t_coef_idx'(CFG_IDX_W'(i)), CW));
            end
        end else if (i_cfg_we && (i_cfg_idx < CFG_IDX_W'(NUM_COEF))) begin
            r_coef[i_cfg_idx] <= i_cfg_data;
        end
    end

    // operand digit: lower digits unsigned, top digit carries the sign
    always_comb begin
        case (ctrl.osel)
            OPND_D1: opnd = r_d1;
            OPND_D2: opnd = r_d2;
            OPND_W:  opnd = r_w;
            default: opnd = r_d1;
        endcase
        opnd_ext = OPW'(opnd);
        dig_raw  = opnd_ext[int'(digit) * DIG_W +: DIG_W];
        if (digit == CNT_W'(NDIG - 1)) begin
            dig_s = {dig_raw[DIG_W-1], dig_raw};
        end else begin
            dig_s = {1'b0, dig_raw};
        end
    end

    // product scaling: floor shift, then clamp to +-2^61
    always_comb begin
        pp_ext = PW'(r_pp);
        pp_sh  = pp_ext <<< (int'(r_pp_k) * DIG_W);
        sc     = r_prod[PW-1:CF];
        sc_ext = EXTW'(sc);
        if (sc_ext > PROD_LIM) begin
            sc_clamp = PROD_LIM;
        end else if (sc_ext < NEG_LIM) begin
            sc_clamp = NEG_LIM;
        end else begin
            sc_clamp = sc_ext;
        end
        prod_term = SUMW'(sc_clamp);
        x_in      = SUMW'(i_sample_in) <<< IN_SH;
    end

    // internal node saturation and output rounding toward zero
    always_comb begin
        w_fits = (&r_sum[SUMW-1:SW-1]) || !(|r_sum[SUMW-1:SW-1]);
        if (w_fits) begin
            w_sat = r_sum[SW-1:0];
        end else if (r_sum[SUMW-1]) begin
            w_sat = {1'b1, {(SW-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(SW-1){1'b1}}};
        end
        y_biased = r_sum + (r_sum[SUMW-1] ? RND_BIAS : '0);
        q        = y_biased[SUMW-1:IN_SH];
        q_fits   = (&q[QW-1:15]) || !(|q[QW-1:15]);
        if (q_fits) begin
            y_sat = q[15:0];
        end else if (q[QW-1]) begin
            y_sat = 16'sh8000;
        end else begin
            y_sat = 16'sh7fff;
        end
    end

    // multiplier and product accumulation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp_vld <= 1'b0;
        end else begin
            r_pp_vld <= ctrl.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.mul_en) begin
            r_pp       <= r_coef[ctrl.csel] * dig_s;
            r_pp_k     <= digit;
            r_pp_first <= (digit == '0);
        end
        if (r_pp_vld) begin
            r_prod <= (r_pp_first ? '0 : r_prod) + pp_sh;
        end
    end

    // running sum and internal node
    always_ff @(posedge i_clk) begin
        if (ctrl.take_in) begin
            r_sum <= x_in;
        end else begin
            case (ctrl.sum_op)
                SUM_ADD:  r_sum <= r_sum + prod_term;
                SUM_SUB:  r_sum <= r_sum - prod_term;
                SUM_CLR:  r_sum <= '0;
                default:  r_sum <= r_sum;
            endcase
        end
        if (ctrl.wsat) begin
            r_w <= w_sat;
        end
    end

    // delay line shifts as the result is issued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else if (ctrl.emit) begin
            r_d2 <= r_d1;
            r_d1 <= r_w;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.emit) begin
            r_sample_out <= y_sat;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;

endmodule

// ----- tb/biquad_iir_direct_form_ii_tb.sv -----
`timescale 1ns / 1ps

module biquad_iir_direct_form_ii_tb;
    import bq_iir_pkg::*;

    localparam int STATE_W        = 40;
    localparam int COEF_W         = 32;
    localparam int COEF_FRAC      = COEF_W - 2;
    localparam int IN_SHIFT       = STATE_W - 16 - 15;
    localparam int LATENCY        = 5 * ((STATE_W + DIG_W - 1) / DIG_W) + 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_SAMPLES  = 96;
    localparam longint STABLE_A2_MAX = 966367641;  // about 0.9 in Q2.30

    localparam logic signed [63:0] NODE_MAX = (64'sd1 <<< (STATE_W - 1)) - 1;
    localparam logic signed [63:0] NODE_MIN = -(64'sd1 <<< (STATE_W - 1));
    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W - 1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W - 1){1'b0}}};
    localparam logic signed [COEF_W-1:0] COEF_ONE = {2'b01, {COEF_FRAC{1'b0}}};
    localparam logic signed [COEF_W-1:0] HIGHPASS_SET [NUM_COEF] = '{
        -32'sd1988727151, 32'sd925939788, 32'sd997102192, -32'sd1994204383, 32'sd997102192
    };

    typedef enum {
        SET_HIGHPASS,
        SET_STABLE,
        SET_RANDOM,
        SET_ALL_MAX,
        SET_ALL_MIN,
        SET_ZERO,
        SET_PASS
    } t_coef_set;

    localparam t_coef_set PHASE_PLAN [RANDOM_PHASES] = '{
        SET_STABLE, SET_HIGHPASS, SET_RANDOM, SET_STABLE, SET_ALL_MAX, SET_STABLE,
        SET_ALL_MIN, SET_PASS, SET_RANDOM, SET_STABLE, SET_ZERO, SET_STABLE
    };

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    logic                     o_in_ready;
    logic signed [15:0]       i_sample_in = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic signed [15:0]       o_sample_out;
    logic                     i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_idx   = '0;
    logic [COEF_W-1:0]        i_cfg_data  = '0;

    // filter state as the block should hold it
    logic signed [COEF_W-1:0]  coef_q [NUM_COEF];
    logic signed [STATE_W-1:0] node_d1 = '0;
    logic signed [STATE_W-1:0] node_d2 = '0;
    logic signed [15:0]        pending_outputs [$];
    logic signed [15:0]        want_sample;

    int mismatches      = 0;
    int samples_sent    = 0;
    int results_checked = 0;
    int coef_writes     = 0;
    int quiet_cycles    = 0;
    int stall_left      = 0;
    bit in_idle_on      = 1'b1;
    bit out_stall_on    = 1'b1;

    biquad_iir_direct_form_ii #(
        .STATE_WIDTH (STATE_W),
        .COEF_WIDTH  (COEF_W)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // exact product, then floor shift by the coefficient fraction bits
    function automatic logic signed [63:0] scaled_product(logic signed [COEF_W-1:0] c,
                                                          logic signed [STATE_W-1:0] s);
        logic signed [COEF_W+STATE_W-1:0] p;
        p = c * s;
        return 64'(p >>> COEF_FRAC);
    endfunction

    function automatic logic signed [15:0] biquad_step(logic signed [15:0] x_in);
        logic signed [63:0] x;
        logic signed [63:0] w;
        logic signed [63:0] y;
        logic signed [63:0] r;
        x = x_in;
        x = x <<< IN_SHIFT;
        w = x - scaled_product(coef_q[COEF_A1], node_d1)
              - scaled_product(coef_q[COEF_A2], node_d2);
        if (w > NODE_MAX) begin
            w = NODE_MAX;
        end else if (w < NODE_MIN) begin
            w = NODE_MIN;
        end
        y = scaled_product(coef_q[COEF_B0], w[STATE_W-1:0])
          + scaled_product(coef_q[COEF_B1], node_d1)
          + scaled_product(coef_q[COEF_B2], node_d2);
        node_d2 = node_d1;
        node_d1 = w[STATE_W-1:0];
        // truncate toward zero, then clamp to 16 bits
        if (y >= 0) begin
            r = y >>> IN_SHIFT;
        end else begin
            r = -((-y) >>> IN_SHIFT);
        end
        if (r > 32767) begin
            r = 32767;
        end else if (r < -32768) begin
            r = -32768;
        end
        return r[15:0];
    endfunction

    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [15:0] random_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 16'($urandom);
        if (r < 70) return 16'(int'($urandom_range(0, 511)) - 256);
        if (r < 85) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        if (r < 92) return $urandom_range(0, 1) ? 16'sh0000 : 16'shffff;
        return 16'($urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 99))
                                        : -32768 + int'($urandom_range(0, 99)));
    endfunction

    task automatic report_mismatch(string what, logic signed [15:0] want_v,
                                   logic signed [15:0] got_v);
        $display("[%0t] mismatch on %s: expected %0d, got %0d (result beat %0d)",
                 $time, what, want_v, got_v, results_checked);
        mismatches++;
    endtask

    task automatic send_sample(logic signed [15:0] s);
        int gap;
        gap = (in_idle_on && $urandom_range(0, 99) < 35) ? pick_idle_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= s;
        do @(posedge i_clk); while (!o_in_ready);
        pending_outputs.push_back(biquad_step(s));
        samples_sent++;
    endtask

    // drain every pending result, then give the sequencer time to go idle
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx < NUM_COEF) coef_q[idx] = data;
        coef_writes++;
    endtask

    task automatic load_coef_set(t_coef_set kind);
        logic signed [COEF_W-1:0] v [NUM_COEF];
        longint a2;
        longint lim;
        v = '{default: '0};
        case (kind)
            SET_HIGHPASS: begin
                v = HIGHPASS_SET;
            end
            SET_STABLE: begin
                // poles inside the unit circle, feedforward gains of random size
                a2  = longint'($urandom_range(0, 2 * STABLE_A2_MAX)) - STABLE_A2_MAX;
                lim = ((longint'(1) <<< COEF_FRAC) + a2) * 95 / 100;
                v[COEF_A1] = COEF_W'(longint'($urandom_range(0, 2 * lim)) - lim);
                v[COEF_A2] = COEF_W'(a2);
                v[COEF_B0] = $signed(COEF_W'($urandom)) >>> $urandom_range(0, 3);
                v[COEF_B1] = $signed(COEF_W'($urandom)) >>> $urandom_range(0, 3);
                v[COEF_B2] = $signed(COEF_W'($urandom)) >>> $urandom_range(0, 3);
            end
            SET_RANDOM: begin
                foreach (v[i]) v[i] = COEF_W'($urandom);
            end
            SET_ALL_MAX: begin
                v = '{default: COEF_MAX};
            end
            SET_ALL_MIN: begin
                v = '{default: COEF_MIN};
            end
            SET_PASS: begin
                v[COEF_B0] = COEF_ONE;
            end
            default: begin
                v = '{default: '0};
            end
        endcase
        write_coef(COEF_A1, v[COEF_A1]);
        write_coef(COEF_A2, v[COEF_A2]);
        write_coef(COEF_B0, v[COEF_B0]);
        write_coef(COEF_B1, v[COEF_B1]);
        write_coef(COEF_B2, v[COEF_B2]);
    endtask

    // high-pass set straight out of reset: impulse, silence, full-scale steps
    task automatic test_highpass_reset();
        send_sample(16'sh7fff);
        send_sample(16'sh0000);
        send_sample(16'sh0000);
        send_sample(16'sh0000);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        send_sample(16'sh0001);
        settle();
    endtask

    // growing oscillation that clamps the internal node at both rails
    // and drives the output into saturation
    task automatic test_node_saturation();
        write_coef(COEF_A1, COEF_MAX);
        write_coef(COEF_A2, COEF_MIN);
        write_coef(COEF_B0, COEF_MAX);
        write_coef(COEF_B1, COEF_MIN);
        write_coef(COEF_B2, COEF_MAX);
        repeat (14) send_sample(16'sh7fff);
        settle();
    endtask

    // writes to unused register indexes must not disturb the coefficients
    task automatic test_bad_index();
        load_coef_set(SET_PASS);
        for (int i = NUM_COEF; i < 2 ** CFG_IDX_W; i++) begin
            write_coef(CFG_IDX_W'(i), COEF_W'($urandom));
        end
        send_sample(16'sh1234);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        settle();
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            in_idle_on   = (p % 4 != 3);
            out_stall_on = (p % 3 != 2);
            load_coef_set(PHASE_PLAN[p]);
            repeat (PHASE_SAMPLES) send_sample(random_sample());
            settle();
        end
    endtask

    // output side backpressure
    always @(posedge i_clk) begin
        if (stall_left == 0 && out_stall_on && $urandom_range(0, 99) < 30)
            stall_left = pick_idle_len();
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_checked++;
            if (pending_outputs.size() == 0) begin
                report_mismatch("unexpected result beat", '0, o_sample_out);
            end else begin
                want_sample = pending_outputs.pop_front();
                if (o_sample_out !== want_sample)
                    report_mismatch("sample_out", want_sample, o_sample_out);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, pending_outputs.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        coef_q = HIGHPASS_SET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_highpass_reset();
        test_node_saturation();
        test_bad_index();
        test_random_phases();

        $display("%0d samples in, %0d results checked, %0d mismatches",
                 samples_sent, results_checked, mismatches);
        $display("%0d coefficient writes: reset set, rail values, unused indexes, %0d random sets",
                 coef_writes, RANDOM_PHASES);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/bq_iir_pkg.sv
rtl/core/bq_iir_seq.sv
rtl/core/biquad_iir_direct_form_ii.sv
tb/biquad_iir_direct_form_ii_tb.sv
